// ===== rtl/core/eca_pkg.sv =====
package eca_pkg;

    localparam int CELLS_DEF       = 16;
    localparam int GENERATIONS_DEF = 16;
    localparam int GATE_ROWS_DEF   = 4;

    localparam int RULE_W   = 8;
    localparam int SEED_W   = 16;
    localparam int WINDOW_W = 2;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int GATE_W   = 4;
    localparam int COL_OUT_W = 4;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_RULE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;

    localparam logic [RULE_W-1:0]   RULE_RESET   = 8'd30;
    localparam logic [SEED_W-1:0]   SEED_RESET   = 16'h0100;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 2'd0;

endpackage

// ===== rtl/core/eca_cell.sv =====
module eca_cell
    import eca_pkg::*;
#(
    parameter int CELLS = CELLS_DEF
) (
    input  logic                     i_clk,
    input  logic [RULE_W-1:0]        i_rule,
    input  logic [CELLS-1:0]         i_row,
    input  logic [$clog2(CELLS)-1:0] i_col,
    output logic [CELLS-1:0]         o_row,
    output logic                     o_tap
);

    logic [CELLS-1:0] r_row;
    logic [CELLS-1:0] n_row;

    // next generation of the row handed over by the previous cell, or of the seed row for the first cell
    always_comb begin
        for (int x = 0; x < CELLS; x++) begin
            n_row[x] = i_rule[{i_row[(x + CELLS - 1) % CELLS],
                               i_row[x],
                               i_row[(x + 1) % CELLS]}];
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
    end

    assign o_row = r_row;
    assign o_tap = r_row[i_col];

endmodule

// ===== rtl/core/elementary_cellular_automaton_sequencer_top.sv =====
// The result of an accepted request is registered before it drives the output.
// Throughput: one request per cycle; a waiting result holds off the next request.
// The generation store is a chain of row cells, each one rule step behind its neighbor,
// so it refills after reset or a rule or seed write; a settle counter holds off requests meanwhile.
// Reset (synchronous, active low) loads rule 30, seed 0x0100, window 0, column 0, empty output.
module elementary_cellular_automaton_sequencer_top
    import eca_pkg::*;
#(
    parameter int CELLS       = CELLS_DEF,
    parameter int GENERATIONS = GENERATIONS_DEF,
    parameter int GATE_ROWS   = GATE_ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [0] advance, [1] clear_step, [7:2] zero
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // [3:0] gate_bits, [7:4] column
);

    localparam int COL_W    = $clog2(CELLS);
    localparam int GEN_W    = $clog2(GENERATIONS);
    localparam int SEL_W    = GEN_W + 1;
    localparam int GATE_OUT = (GATE_ROWS < GATE_W) ? GATE_ROWS : GATE_W;

    logic [RULE_W-1:0]   r_rule;
    logic [SEED_W-1:0]   r_seed;
    logic [WINDOW_W-1:0] r_window;
    logic [GEN_W-1:0]    r_settle;
    logic [COL_W-1:0]    r_col;
    logic                r_out_valid;
    logic [GATE_W-1:0]   r_gates;
    logic [COL_OUT_W-1:0] r_col_out;

    logic [COL_W-1:0]    n_col;
    logic [GATE_W-1:0]   n_gates;
    logic [COL_OUT_W-1:0] n_col_out;
    logic                w_accept;
    logic                w_rebuild;
    logic [CELLS-1:0]    w_rows [GENERATIONS];
    logic [GENERATIONS-1:0] w_taps;
    logic [CELLS+SEED_W-1:0] w_seed_ext;
    logic [COL_W+COL_OUT_W-1:0] w_col_ext;

    assign w_rebuild = i_cfg_we && (i_cfg_idx == REG_RULE || i_cfg_idx == REG_SEED);
    assign s_axis_tready = (r_settle == '0) && (!r_out_valid || m_axis_tready);
    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule   <= RULE_RESET;
            r_seed   <= SEED_RESET;
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RULE:   r_rule   <= i_cfg_data[RULE_W-1:0];
                REG_SEED:   r_seed   <= i_cfg_data[SEED_W-1:0];
                REG_WINDOW: r_window <= i_cfg_data[WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    // hold off requests until the chain has refilled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_rebuild) begin
            r_settle <= GEN_W'(GENERATIONS - 1);
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 1'b1;
        end
    end

    always_comb begin
        n_col = r_col;
        if (s_axis_tdata[0]) begin
            n_col = (r_col == COL_W'(CELLS - 1)) ? '0 : r_col + 1'b1;
        end
        if (s_axis_tdata[1]) begin
            n_col = '0;
        end
    end

    assign w_seed_ext = {{CELLS{1'b0}}, r_seed};
    assign w_rows[0]  = w_seed_ext[CELLS-1:0];
    assign w_taps[0]  = w_rows[0][n_col];

    for (genvar g = 1; g < GENERATIONS; g++) begin : g_cells
        eca_cell #(
            .CELLS(CELLS)
        ) u_cell (
            .i_clk (i_clk),
            .i_rule(r_rule),
            .i_row (w_rows[g-1]),
            .i_col (n_col),
            .o_row (w_rows[g]),
            .o_tap (w_taps[g])
        );
    end

    always_comb begin
        logic [SEL_W-1:0] sel;
        n_gates = '0;
        for (int i = 0; i < GATE_OUT; i++) begin
            sel = SEL_W'(r_window) + SEL_W'(i);
            if (sel < SEL_W'(GENERATIONS)) begin
                n_gates[i] = w_taps[sel[GEN_W-1:0]];
            end
        end
    end

    assign w_col_ext = {{COL_OUT_W{1'b0}}, n_col};
    assign n_col_out = w_col_ext[COL_OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_col       <= n_col;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_gates   <= n_gates;
            r_col_out <= n_col_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_col_out, r_gates};

    a_no_accept_settling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_settle != '0) |-> !w_accept)
        else $error("request accepted while generation chain settles");

    a_rebuild_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rebuild |=> !s_axis_tready)
        else $error("request path open right after rule or seed write");

    a_clear_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tdata[1]) |=> (m_axis_tvalid && m_axis_tdata[7:4] == 4'd0))
        else $error("clear did not zero the column");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_col <= COL_W'(CELLS - 1)))
        else $error("column step past the ring");

endmodule
